/* hw/rtl/nrtp_pkg.sv */
// Shared types and constants for the nested region time profiler.
package nrtp_pkg;

	// Table and stack sizes
	localparam int REGION_POINTS = 64;
	localparam int EVENT_POINTS  = 64;
	localparam int STACK_DEPTH   = 16;

	// Fixed field widths
	localparam int FUNC_W  = 3;
	localparam int POINT_W = 6;
	localparam int TS_W    = 64;
	localparam int DELTA_W = 32;
	localparam int STS_W   = 2;
	localparam int VAL_W   = 64;
	localparam int DOUT_W  = 5;

	// Derived widths
	localparam int RG_AW   = (REGION_POINTS > 1) ? $clog2(REGION_POINTS) : 1;
	localparam int EV_AW   = (EVENT_POINTS > 1) ? $clog2(EVENT_POINTS) : 1;
	localparam int SP_AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_BEGIN    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_END      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ADD_EVT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RD_REG   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RD_EVT   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd5;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [POINT_W-1:0] point;
		logic [TS_W-1:0]    timestamp;
		logic [DELTA_W-1:0] delta;
	} in_req_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [VAL_W-1:0]  value_out;
		logic [VAL_W-1:0]  count_out;
		logic [DOUT_W-1:0] depth_out;
	} out_rsp_t;

	// Table read request
	typedef struct packed {
		logic             en;
		logic [RG_AW-1:0] rg_addr;
		logic [EV_AW-1:0] ev_addr;
	} tbl_rd_t;

	// Table write-back and clear
	typedef struct packed {
		logic             clear;
		logic             cost_we;
		logic             ent_we;
		logic             evt_we;
		logic [RG_AW-1:0] rg_addr;
		logic [EV_AW-1:0] ev_addr;
		logic [VAL_W-1:0] cost_wd;
		logic [VAL_W-1:0] ent_wd;
		logic [VAL_W-1:0] evt_wd;
	} tbl_wr_t;

endpackage

/* hw/rtl/nrtp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module nrtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/nrtp_tables.sv */
// Region cost, region entry and event total tables with per-entry valid bits.
module nrtp_tables (
	input  logic              clk,
	input  logic              arst_n,
	input  nrtp_pkg::tbl_rd_t rd,
	input  nrtp_pkg::tbl_wr_t wr,
	output logic [63:0]       cost_rd,
	output logic [63:0]       ent_rd,
	output logic [63:0]       evt_rd
);
	import nrtp_pkg::*;

	logic [REGION_POINTS-1:0] cost_vld_q;
	logic [REGION_POINTS-1:0] ent_vld_q;
	logic [EVENT_POINTS-1:0]  evt_vld_q;
	logic                     cost_hit_q;
	logic                     ent_hit_q;
	logic                     evt_hit_q;
	logic [VAL_W-1:0]         cost_raw;
	logic [VAL_W-1:0]         ent_raw;
	logic [VAL_W-1:0]         evt_raw;

	nrtp_ram #(.WIDTH(VAL_W), .DEPTH(REGION_POINTS)) u_cost_ram (
		.clk   (clk),
		.we    (wr.cost_we),
		.waddr (wr.rg_addr),
		.wdata (wr.cost_wd),
		.re    (rd.en),
		.raddr (rd.rg_addr),
		.rdata (cost_raw)
	);

	nrtp_ram #(.WIDTH(VAL_W), .DEPTH(REGION_POINTS)) u_ent_ram (
		.clk   (clk),
		.we    (wr.ent_we),
		.waddr (wr.rg_addr),
		.wdata (wr.ent_wd),
		.re    (rd.en),
		.raddr (rd.rg_addr),
		.rdata (ent_raw)
	);

	nrtp_ram #(.WIDTH(VAL_W), .DEPTH(EVENT_POINTS)) u_evt_ram (
		.clk   (clk),
		.we    (wr.evt_we),
		.waddr (wr.ev_addr),
		.wdata (wr.evt_wd),
		.re    (rd.en),
		.raddr (rd.ev_addr),
		.rdata (evt_raw)
	);

	// valid bits: a clear drops them all, a write marks its entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_vld_q <= '0;
			ent_vld_q  <= '0;
			evt_vld_q  <= '0;
		end else if (wr.clear) begin
			cost_vld_q <= '0;
			ent_vld_q  <= '0;
			evt_vld_q  <= '0;
		end else begin
			if (wr.cost_we) cost_vld_q[wr.rg_addr] <= 1'b1;
			if (wr.ent_we)  ent_vld_q[wr.rg_addr]  <= 1'b1;
			if (wr.evt_we)  evt_vld_q[wr.ev_addr]  <= 1'b1;
		end
	end

	// valid bit sampled alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_hit_q <= 1'b0;
			ent_hit_q  <= 1'b0;
			evt_hit_q  <= 1'b0;
		end else if (rd.en) begin
			cost_hit_q <= cost_vld_q[rd.rg_addr];
			ent_hit_q  <= ent_vld_q[rd.rg_addr];
			evt_hit_q  <= evt_vld_q[rd.ev_addr];
		end
	end

	// never-written entries read as zero
	assign cost_rd = cost_hit_q ? cost_raw : '0;
	assign ent_rd  = ent_hit_q  ? ent_raw  : '0;
	assign evt_rd  = evt_hit_q  ? evt_raw  : '0;

endmodule

/* hw/rtl/nested_region_time_profiler_top.sv */
// Top level of the nested region time profiler: sequencer, region stack and output register.
//
// Usage:
//   One input channel (in_valid / in_ready / in_data) carries requests: begin
//   region, end region, add event, read region, read event, clear. Every
//   request yields exactly one response on the output channel (out_valid /
//   out_ready / out_data) with a status, the read values and the stack depth.
//   Each request passes through a stack RAM read, a table RAM read, and
//   the update cycle that writes back and loads the response register. The
//   serial chain stack read -> table read -> write-back allows one request in
//   flight, so a new request is accepted only once the last has committed.
//   The response register is loaded at that commit, in the update state.
//   The response register is separate from the sequencer: the next request
//   is accepted while a response waits. If the receiver stalls, the update of
//   the following request waits, with in_ready low, until the slot frees.
//   Reset (arst_n low) empties the stack and marks every table entry as zero
//   through per-entry valid bits; no clearing pass is needed, and a clear
//   request takes effect in its own update cycle.
module nested_region_time_profiler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nrtp_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nrtp_pkg::out_rsp_t out_data
);
	import nrtp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STK  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t             state_q;
	in_req_t            item_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [TS_W-1:0]    elapsed_s2;
	logic [RG_AW-1:0]   rg_addr_s2;
	logic               top_ok_s2;
	logic               out_valid_q;
	out_rsp_t           out_q;

	logic               accept;
	logic               commit;
	logic [POINT_W-1:0] stk_reg_rd;
	logic [TS_W-1:0]    stk_ts_rd;
	logic               reg_we;
	logic               start_we;
	logic [SP_AW-1:0]   stk_waddr;
	logic [SP_AW-1:0]   stk_top;
	logic               pt_rg_ok;
	logic               pt_ev_ok;
	logic               stk_full;
	logic               stk_empty;
	tbl_rd_t            tbl_rd;
	tbl_wr_t            tbl_wr;
	logic [VAL_W-1:0]   cost_rd;
	logic [VAL_W-1:0]   ent_rd;
	logic [VAL_W-1:0]   evt_rd;
	logic [DEPTH_W-1:0] depth_nxt;
	out_rsp_t           rsp_nxt;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign commit    = (state_q == S_UPD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stk_top   = SP_AW'(depth_q - DEPTH_W'(1));
	assign stk_full  = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign stk_empty = (depth_q == '0);
	assign pt_rg_ok  = (32'(item_q.point) < REGION_POINTS);
	assign pt_ev_ok  = (32'(item_q.point) < EVENT_POINTS);

	// region and start stacks, read at the top on accept
	nrtp_ram #(.WIDTH(POINT_W), .DEPTH(STACK_DEPTH)) u_reg_stk (
		.clk   (clk),
		.we    (reg_we),
		.waddr (stk_waddr),
		.wdata (item_q.point),
		.re    (accept),
		.raddr (stk_top),
		.rdata (stk_reg_rd)
	);

	nrtp_ram #(.WIDTH(TS_W), .DEPTH(STACK_DEPTH)) u_start_stk (
		.clk   (clk),
		.we    (start_we),
		.waddr (stk_waddr),
		.wdata (item_q.timestamp),
		.re    (accept),
		.raddr (stk_top),
		.rdata (stk_ts_rd)
	);

	nrtp_tables u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.wr      (tbl_wr),
		.cost_rd (cost_rd),
		.ent_rd  (ent_rd),
		.evt_rd  (evt_rd)
	);

	// table read: begin/end address the stack top region, the rest the point
	always_comb begin
		tbl_rd.en      = (state_q == S_STK);
		tbl_rd.ev_addr = EV_AW'(item_q.point);
		if (item_q.func == FN_BEGIN || item_q.func == FN_END) begin
			tbl_rd.rg_addr = RG_AW'(stk_reg_rd);
		end else begin
			tbl_rd.rg_addr = RG_AW'(item_q.point);
		end
	end

	// update cycle: status, write-back, stack pointer
	always_comb begin
		rsp_nxt        = '0;
		depth_nxt      = depth_q;
		reg_we         = 1'b0;
		start_we       = 1'b0;
		stk_waddr      = SP_AW'(depth_q);
		tbl_wr         = '0;
		tbl_wr.rg_addr = rg_addr_s2;
		tbl_wr.ev_addr = EV_AW'(item_q.point);
		tbl_wr.cost_wd = cost_rd + elapsed_s2;
		tbl_wr.ent_wd  = ent_rd + VAL_W'(1);
		tbl_wr.evt_wd  = evt_rd + VAL_W'(item_q.delta);
		case (item_q.func)
			FN_BEGIN: begin
				if (pt_rg_ok) begin
					if (stk_full) begin
						rsp_nxt.status = STS_FULL;
					end else begin
						tbl_wr.cost_we = commit && !stk_empty && top_ok_s2;
						reg_we         = commit;
						start_we       = commit;
						depth_nxt      = depth_q + DEPTH_W'(1);
					end
				end
			end
			FN_END: begin
				if (stk_empty) begin
					rsp_nxt.status = STS_EMPTY;
				end else begin
					tbl_wr.cost_we = commit && top_ok_s2;
					tbl_wr.ent_we  = commit && top_ok_s2;
					depth_nxt      = depth_q - DEPTH_W'(1);
					// restart the outer region's timer
					stk_waddr      = SP_AW'(depth_q - DEPTH_W'(2));
					start_we       = commit && (depth_q > DEPTH_W'(1));
				end
			end
			FN_ADD_EVT: begin
				tbl_wr.evt_we = commit && pt_ev_ok;
			end
			FN_RD_REG: begin
				if (pt_rg_ok) begin
					rsp_nxt.value_out = cost_rd;
					rsp_nxt.count_out = ent_rd;
				end
			end
			FN_RD_EVT: begin
				if (pt_ev_ok) begin
					rsp_nxt.value_out = evt_rd;
				end
			end
			FN_CLEAR: begin
				tbl_wr.clear = commit;
				depth_nxt    = '0;
			end
			default: begin
			end
		endcase
		rsp_nxt.depth_out = DOUT_W'(depth_nxt);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_STK;
				end
				S_STK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
						depth_q <= depth_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	// stack stage results carried to the update cycle
	always_ff @(posedge clk) begin
		if (state_q == S_STK) begin
			elapsed_s2 <= item_q.timestamp - stk_ts_rd;
			rg_addr_s2 <= tbl_rd.rg_addr;
			top_ok_s2  <= (32'(stk_reg_rd) < REGION_POINTS);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= rsp_nxt;
		end
	end

endmodule

/* hw/rtl/nrtp_checker.sv */
// Port-level checks for the nested region time profiler, bound to the top level.
module nrtp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input nrtp_pkg::in_req_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input nrtp_pkg::out_rsp_t out_data
);
	import nrtp_pkg::*;

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while waiting");

	// a stalled response holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// one request in flight: accept closes the input for the next cycle
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a full status only comes with a full stack
	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != STS_FULL
			|| out_data.depth_out == DOUT_W'(STACK_DEPTH))
		else $error("full status with stack not full");

	// an ignored end leaves an empty stack and no read data
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STS_EMPTY |->
			out_data.depth_out == '0 && out_data.value_out == '0
			&& out_data.count_out == '0)
		else $error("empty status with open regions or data");

endmodule

bind nested_region_time_profiler_top nrtp_checker u_nrtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
